@@ rtl/psfc_pkg.sv @@
package psfc_pkg;

  // Input sample encodings
  typedef enum logic [2:0] {
    IN_U8  = 3'd0,
    IN_I16 = 3'd1,
    IN_I24 = 3'd2,
    IN_I32 = 3'd3,
    IN_F32 = 3'd4,
    IN_F64 = 3'd5
  } in_fmt_e;

  // Output sample encodings
  typedef enum logic [2:0] {
    OUT_I16     = 3'd0,
    OUT_I24     = 3'd1,
    OUT_I32     = 3'd2,
    OUT_F32     = 3'd3,
    OUT_F64     = 3'd4,
    OUT_I16IN32 = 3'd5,
    OUT_I24IN32 = 3'd6
  } out_fmt_e;

  // Value class after decode
  typedef enum logic [1:0] {
    CLS_NUM  = 2'd0,
    CLS_ZERO = 2'd1,
    CLS_INF  = 2'd2,
    CLS_NAN  = 2'd3
  } cls_e;

  // Configuration register indexes
  localparam logic CFG_IN_FORMAT  = 1'b0;
  localparam logic CFG_OUT_FORMAT = 1'b1;

  localparam logic [31:0] CANON_F32 = 32'h7fc0_0000;
  localparam logic [31:0] ONE_F32   = 32'h3f80_0000;
  localparam logic [63:0] CANON_F64 = 64'h7ff8_0000_0000_0000;
  localparam logic [63:0] ONE_F64   = 64'h3ff0_0000_0000_0000;

  // Sample as sign, 53-bit significand and exponent: value = mant / 2^52 * 2^expo
  typedef struct packed {
    logic               valid;
    logic [4:0]         chan;
    logic               zero_out;
    in_fmt_e            in_fmt;
    out_fmt_e           out_fmt;
    logic               sign;
    cls_e               cls;
    logic [52:0]        mant;
    logic signed [12:0] expo;
    logic [63:0]        raw;
  } samp_t;

  // Aligned significand with rounding information
  typedef struct packed {
    logic        valid;
    logic [4:0]  chan;
    logic        zero_out;
    out_fmt_e    out_fmt;
    logic        sign;
    cls_e        cls;
    logic        sat;
    logic        clamp;
    logic [31:0] kept;
    logic        half;
    logic        sticky;
    logic [7:0]  ef;
    logic [63:0] f64_word;
  } algn_t;

endpackage

@@ rtl/pcm_sample_format_converter.sv @@
// PCM sample format converter. One sample is taken in every cycle (busy_o never
// rises) and its converted beat leaves the round/pack stage, marked by done_o for
// one cycle; the receiver cannot stall, so it must take each beat as it comes.
// The four register stages are decode, normalise, align and round/pack, each one
// sample wide, which sets the latency. Write in_format and out_format only while
// no sample is in flight; samples in flight use the formats seen at their start.
module pcm_sample_format_converter (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [4:0]  channel_i,
  input  logic        silence_i,
  input  logic [63:0] in_sample_i,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [2:0]  cfg_data_i,
  output logic        done_o,
  output logic [4:0]  out_channel_o,
  output logic [63:0] out_sample_o
);

  psfc_pkg::in_fmt_e  in_fmt_q;
  psfc_pkg::out_fmt_e out_fmt_q;
  psfc_pkg::samp_t    s1, s2;
  psfc_pkg::algn_t    s3;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_fmt_q  <= psfc_pkg::IN_I16;
      out_fmt_q <= psfc_pkg::OUT_I16;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == psfc_pkg::CFG_IN_FORMAT) begin
        in_fmt_q <= psfc_pkg::in_fmt_e'(cfg_data_i);
      end else begin
        out_fmt_q <= psfc_pkg::out_fmt_e'(cfg_data_i);
      end
    end
  end

  assign busy_o = 1'b0;

  psfc_unpack u_unpack (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .channel_i   (channel_i),
    .silence_i   (silence_i),
    .in_sample_i (in_sample_i),
    .in_fmt_i    (in_fmt_q),
    .out_fmt_i   (out_fmt_q),
    .samp_o      (s1)
  );

  psfc_norm u_norm (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .samp_i (s1),
    .samp_o (s2)
  );

  psfc_align u_align (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .samp_i (s2),
    .algn_o (s3)
  );

  psfc_pack u_pack (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .algn_i   (s3),
    .valid_o  (done_o),
    .chan_o   (out_channel_o),
    .sample_o (out_sample_o)
  );

endmodule

@@ rtl/psfc_unpack.sv @@
module psfc_unpack (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [4:0]         channel_i,
  input  logic               silence_i,
  input  logic [63:0]        in_sample_i,
  input  psfc_pkg::in_fmt_e  in_fmt_i,
  input  psfc_pkg::out_fmt_e out_fmt_i,
  output psfc_pkg::samp_t    samp_o
);

  psfc_pkg::samp_t samp_d, samp_q;
  logic signed [32:0] x;
  logic [32:0] mag;
  logic is_int;

  // Decode the raw beat into sign, significand and exponent
  always_comb begin
    samp_d          = '0;
    samp_d.valid    = start_i;
    samp_d.chan     = channel_i;
    samp_d.zero_out = silence_i;
    samp_d.in_fmt   = in_fmt_i;
    samp_d.out_fmt  = out_fmt_i;
    samp_d.raw      = in_sample_i;
    samp_d.cls      = psfc_pkg::CLS_ZERO;
    x      = '0;
    is_int = 1'b0;
    case (in_fmt_i)
      psfc_pkg::IN_U8: begin
        x = $signed({25'b0, in_sample_i[7:0]}) - 33'sd128;
        samp_d.expo = 13'sd24;
        is_int = 1'b1;
      end
      psfc_pkg::IN_I16: begin
        x = $signed({{17{in_sample_i[15]}}, in_sample_i[15:0]});
        samp_d.expo = 13'sd16;
        is_int = 1'b1;
      end
      psfc_pkg::IN_I24: begin
        x = $signed({{9{in_sample_i[23]}}, in_sample_i[23:0]});
        samp_d.expo = 13'sd8;
        is_int = 1'b1;
      end
      psfc_pkg::IN_I32: begin
        x = $signed({in_sample_i[31], in_sample_i[31:0]});
        samp_d.expo = 13'sd0;
        is_int = 1'b1;
      end
      psfc_pkg::IN_F32: begin
        samp_d.sign = in_sample_i[31];
        if (in_sample_i[30:23] == 8'hff) begin
          samp_d.cls = (in_sample_i[22:0] != '0) ? psfc_pkg::CLS_NAN : psfc_pkg::CLS_INF;
        end else if (in_sample_i[30:23] == 8'h00) begin
          samp_d.mant = {1'b0, in_sample_i[22:0], 29'b0};
          samp_d.expo = -13'sd126;
          samp_d.cls  = (in_sample_i[22:0] == '0) ? psfc_pkg::CLS_ZERO : psfc_pkg::CLS_NUM;
        end else begin
          samp_d.mant = {1'b1, in_sample_i[22:0], 29'b0};
          samp_d.expo = $signed({5'b0, in_sample_i[30:23]}) - 13'sd127;
          samp_d.cls  = psfc_pkg::CLS_NUM;
        end
      end
      psfc_pkg::IN_F64: begin
        samp_d.sign = in_sample_i[63];
        if (in_sample_i[62:52] == 11'h7ff) begin
          samp_d.cls = (in_sample_i[51:0] != '0) ? psfc_pkg::CLS_NAN : psfc_pkg::CLS_INF;
        end else if (in_sample_i[62:52] == 11'h000) begin
          // subnormals are far below any output step: treat as signed zero
          samp_d.cls = psfc_pkg::CLS_ZERO;
        end else begin
          samp_d.mant = {1'b1, in_sample_i[51:0]};
          samp_d.expo = $signed({2'b0, in_sample_i[62:52]}) - 13'sd1023;
          samp_d.cls  = psfc_pkg::CLS_NUM;
        end
      end
      default: samp_d.zero_out = 1'b1;
    endcase
    mag = x[32] ? 33'(-x) : 33'(x);
    if (is_int) begin
      samp_d.sign = x[32];
      samp_d.mant = {mag[31:0], 21'b0};
      samp_d.cls  = (mag == '0) ? psfc_pkg::CLS_ZERO : psfc_pkg::CLS_NUM;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      samp_q <= '0;
    end else begin
      samp_q <= samp_d;
    end
  end

  assign samp_o = samp_q;

endmodule

@@ rtl/psfc_norm.sv @@
module psfc_norm (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  psfc_pkg::samp_t samp_i,
  output psfc_pkg::samp_t samp_o
);

  psfc_pkg::samp_t samp_d, samp_q;
  logic [5:0] lz;

  // Count leading zeros of the significand
  always_comb begin
    lz = 6'd0;
    for (int i = 0; i < 53; i++) begin
      if (samp_i.mant[i]) lz = 6'(52 - i);
    end
  end

  // Shift the leading one to the top of a number's significand; clear it otherwise
  always_comb begin
    samp_d = samp_i;
    if (samp_i.cls == psfc_pkg::CLS_NUM) begin
      samp_d.mant = samp_i.mant << lz;
      samp_d.expo = samp_i.expo - $signed({7'b0, lz});
    end else begin
      samp_d.mant = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      samp_q <= '0;
    end else begin
      samp_q <= samp_d;
    end
  end

  assign samp_o = samp_q;

endmodule

@@ rtl/psfc_align.sv @@
module psfc_align (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  psfc_pkg::samp_t samp_i,
  output psfc_pkg::algn_t algn_o
);

  psfc_pkg::algn_t algn_d, algn_q;
  logic signed [13:0] t_full;
  logic signed [13:0] n_bits;
  logic signed [13:0] expo_x;
  logic [5:0]  t;
  logic [52:0] kept_w;
  logic [52:0] half_w;
  logic [52:0] mask;
  logic        big;
  logic        is_num;

  always_comb begin
    algn_d          = '0;
    algn_d.valid    = samp_i.valid;
    algn_d.chan     = samp_i.chan;
    algn_d.zero_out = samp_i.zero_out;
    algn_d.out_fmt  = samp_i.out_fmt;
    algn_d.sign     = samp_i.sign;
    algn_d.cls      = samp_i.cls;
    expo_x = {samp_i.expo[12], samp_i.expo};
    is_num = (samp_i.cls == psfc_pkg::CLS_NUM);

    // magnitude at or above one
    big = (samp_i.cls == psfc_pkg::CLS_INF) || (is_num && !samp_i.expo[12]);
    algn_d.sat = big;
    algn_d.clamp = (samp_i.cls == psfc_pkg::CLS_INF) ||
                   (is_num && (samp_i.expo > 13'sd0 ||
                    (samp_i.expo == 13'sd0 && samp_i.mant[51:0] != '0)));

    // pick the shift that leaves the integer or float32 significand
    n_bits = 14'sd16;
    t_full = 14'sd29;
    case (samp_i.out_fmt)
      psfc_pkg::OUT_I16, psfc_pkg::OUT_I16IN32: n_bits = 14'sd16;
      psfc_pkg::OUT_I24, psfc_pkg::OUT_I24IN32: n_bits = 14'sd24;
      psfc_pkg::OUT_I32:                        n_bits = 14'sd32;
      default:                                  n_bits = 14'sd16;
    endcase
    if (samp_i.out_fmt == psfc_pkg::OUT_F32) begin
      if (samp_i.expo < -13'sd126) begin
        t_full    = -14'sd97 - expo_x;
        algn_d.ef = 8'd0;
      end else begin
        t_full    = 14'sd29;
        algn_d.ef = 8'(expo_x + 14'sd126);
      end
    end else begin
      t_full = 14'sd53 - n_bits - expo_x;
    end
    if (t_full > 14'sd63) begin
      t = 6'd63;
    end else if (t_full < 14'sd1) begin
      t = 6'd1;
    end else begin
      t = t_full[5:0];
    end

    // split into kept bits, half bit and sticky
    kept_w = samp_i.mant >> t;
    half_w = samp_i.mant >> (t - 6'd1);
    mask   = (53'd1 << t) - 53'd1;
    algn_d.kept   = kept_w[31:0];
    algn_d.half   = half_w[0];
    algn_d.sticky = |(samp_i.mant & (mask >> 1));

    // float64 result needs no rounding
    if (samp_i.cls == psfc_pkg::CLS_NAN) begin
      algn_d.f64_word = psfc_pkg::CANON_F64;
    end else if (algn_d.clamp) begin
      algn_d.f64_word = {samp_i.sign, psfc_pkg::ONE_F64[62:0]};
    end else if (samp_i.in_fmt == psfc_pkg::IN_F64) begin
      algn_d.f64_word = samp_i.raw;
    end else if (samp_i.cls == psfc_pkg::CLS_ZERO) begin
      algn_d.f64_word = {samp_i.sign, 63'b0};
    end else begin
      algn_d.f64_word = {samp_i.sign, 11'(expo_x + 14'sd1023), samp_i.mant[51:0]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      algn_q <= '0;
    end else begin
      algn_q <= algn_d;
    end
  end

  assign algn_o = algn_q;

endmodule

@@ rtl/psfc_pack.sv @@
module psfc_pack (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  psfc_pkg::algn_t algn_i,
  output logic            valid_o,
  output logic [4:0]      chan_o,
  output logic [63:0]     sample_o
);

  logic               valid_q;
  logic [4:0]         chan_q;
  logic [63:0]        sample_d, sample_q;
  logic               inc;
  logic [32:0]        r;
  logic signed [32:0] v;
  logic signed [32:0] hi;
  logic signed [32:0] lo;
  logic signed [32:0] iv;
  logic [30:0]        f32_mag;
  logic               is_nan;

  always_comb begin
    // round to nearest, ties to even
    inc = algn_i.half & (algn_i.sticky | algn_i.kept[0]);
    r   = {1'b0, algn_i.kept} + {32'b0, inc};
    v   = algn_i.sign ? $signed(33'(-r)) : $signed(r);
    is_nan = (algn_i.cls == psfc_pkg::CLS_NAN);

    // saturation bounds of the integer output
    case (algn_i.out_fmt)
      psfc_pkg::OUT_I24, psfc_pkg::OUT_I24IN32: begin
        hi = 33'sd8388607;
        lo = -33'sd8388608;
      end
      psfc_pkg::OUT_I32: begin
        hi = 33'sd2147483647;
        lo = -33'sd2147483648;
      end
      default: begin
        hi = 33'sd32767;
        lo = -33'sd32768;
      end
    endcase
    if (is_nan) begin
      iv = lo;
    end else if (algn_i.sat) begin
      iv = algn_i.sign ? lo : hi;
    end else if (!algn_i.sign && $signed(r) > hi) begin
      iv = hi;
    end else begin
      iv = v;
    end

    f32_mag = {algn_i.ef, 23'b0} + r[30:0];

    // assemble the output word
    case (algn_i.out_fmt)
      psfc_pkg::OUT_I16: sample_d = {48'b0, iv[15:0]};
      psfc_pkg::OUT_I24: sample_d = {40'b0, iv[23:0]};
      psfc_pkg::OUT_I32, psfc_pkg::OUT_I16IN32, psfc_pkg::OUT_I24IN32:
        sample_d = {32'b0, iv[31:0]};
      psfc_pkg::OUT_F32: begin
        if (is_nan) begin
          sample_d = {32'b0, psfc_pkg::CANON_F32};
        end else if (algn_i.clamp) begin
          sample_d = {32'b0, algn_i.sign, psfc_pkg::ONE_F32[30:0]};
        end else if (algn_i.cls == psfc_pkg::CLS_ZERO) begin
          sample_d = {32'b0, algn_i.sign, 31'b0};
        end else begin
          sample_d = {32'b0, algn_i.sign, f32_mag};
        end
      end
      psfc_pkg::OUT_F64: sample_d = algn_i.f64_word;
      default:           sample_d = '0;
    endcase
    if (algn_i.zero_out) sample_d = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= algn_i.valid;
    end
  end

  // hold payload of the output beat
  always_ff @(posedge clk_i) begin
    chan_q   <= algn_i.chan;
    sample_q <= sample_d;
  end

  assign valid_o  = valid_q;
  assign chan_o   = chan_q;
  assign sample_o = sample_q;

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps

module tb;

  // Scoreboard of converted samples awaiting their output beat
  class sample_scoreboard;
    typedef struct {
      logic [4:0]  chan;
      logic [63:0] smp;
    } beat_t;

    beat_t pending[$];
    int    errors = 0;

    function void note(logic [4:0] chan, logic [63:0] smp);
      beat_t b;
      b.chan = chan;
      b.smp  = smp;
      pending.push_back(b);
    endfunction

    function void check(logic [4:0] chan, logic [63:0] smp);
      beat_t b;
      if (pending.size() == 0) begin
        $error("output beat with nothing pending: out_channel %0d out_sample %h", chan, smp);
        errors++;
        return;
      end
      b = pending.pop_front();
      if (b.chan !== chan) begin
        $error("out_channel: expected %0d, actual %0d", b.chan, chan);
        errors++;
      end
      if (b.smp !== smp) begin
        $error("out_sample: expected %h, actual %h", b.smp, smp);
        errors++;
      end
    endfunction
  endclass

  localparam int CYCLE_LIMIT = 100000;

  logic        clk_i;
  logic        rst_ni;
  logic        start_i;
  logic        busy_o;
  logic [4:0]  channel_i;
  logic        silence_i;
  logic [63:0] in_sample_i;
  logic        cfg_we_i;
  logic        cfg_idx_i;
  logic [2:0]  cfg_data_i;
  logic        done_o;
  logic [4:0]  out_channel_o;
  logic [63:0] out_sample_o;

  sample_scoreboard sb;
  logic [2:0] cur_in_fmt;
  logic [2:0] cur_out_fmt;
  logic       busy_seen;
  int         item_cnt;
  int         cycle_cnt;

  pcm_sample_format_converter i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .busy_o       (busy_o),
    .channel_i    (channel_i),
    .silence_i    (silence_i),
    .in_sample_i  (in_sample_i),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .done_o       (done_o),
    .out_channel_o(out_channel_o),
    .out_sample_o (out_sample_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Widen a single-precision word to double precision, exactly
  function automatic logic [63:0] widen_f32(logic [31:0] b);
    logic [23:0] f;
    int          k;
    int          e;
    e = b[30:23];
    f = {1'b0, b[22:0]};
    k = 0;
    if (e == 255) return {b[31], 11'h7ff, b[22:0], 29'd0};
    if (e != 0) return {b[31], 11'(e + 896), b[22:0], 29'd0};
    if (f == 0) return {b[31], 63'd0};
    while (!f[23]) begin
      f = f << 1;
      k++;
    end
    return {b[31], 11'(897 - k), f[22:0], 29'd0};
  endfunction

  // Narrow a double-precision word to single precision, nearest-even
  function automatic logic [31:0] narrow_f64(logic [63:0] b);
    logic [63:0] sig;
    logic [63:0] kept;
    logic        half;
    logic        sticky;
    int          e;
    int          sh;
    e = b[62:52];
    if (e == 2047)
      return (b[51:0] != 0) ? {b[63], 8'hff, 1'b1, b[50:29]} : {b[63], 8'hff, 23'd0};
    if (e == 0) return {b[63], 31'd0};
    sig = {11'd0, 1'b1, b[51:0]};
    e = e - 1023 + 127;
    sh = (e >= 1) ? 29 : 30 - e;
    if (sh > 60) sh = 60;
    kept = sig >> sh;
    half = sig[sh-1];
    sticky = (sig & ((64'd1 << (sh - 1)) - 1)) != 0;
    if (half && (sticky || kept[0])) kept++;
    if (e < 1) return {b[63], kept[30:0]};
    if (kept[24]) begin
      kept = kept >> 1;
      e++;
    end
    if (e >= 255) return {b[63], 8'hff, 23'd0};
    return {b[63], 8'(e), kept[22:0]};
  endfunction

  // Round to nearest-even and clip to [lo, hi]; NaN goes to lo
  function automatic longint round_clip(logic nan, real d, longint lo, longint hi);
    longint t;
    real    fr;
    if (nan) return lo;
    if (d >= real'(hi)) return hi;
    if (d <= real'(lo)) return lo;
    t = longint'($rtoi(d));
    fr = d - real'(t);
    if (fr > 0.5 || (fr == 0.5 && t[0])) t++;
    else if (fr < -0.5 || (fr == -0.5 && t[0])) t--;
    return t;
  endfunction

  function automatic logic [63:0] to_pcm_int(logic is_flt, logic nan, real fd, longint x,
                                             int m, int n, int ob);
    longint hi;
    longint lo;
    longint v;
    hi = (longint'(1) << (n - 1)) - 1;
    lo = -hi - 1;
    if (is_flt) v = round_clip(nan, fd * real'(longint'(1) << (n - 1)), lo, hi);
    else if (m <= n) v = x * (longint'(1) << (n - m));
    else v = round_clip(1'b0, real'(x) / real'(longint'(1) << (m - n)), lo, hi);
    return 64'(v) & ((64'd1 << ob) - 1);
  endfunction

  // Predict the converted sample bits for one input beat
  function automatic logic [63:0] convert_sample(logic [2:0] ifmt, logic [2:0] ofmt,
                                                 logic sil, logic [63:0] raw);
    logic        is_flt;
    logic        nan;
    real         fd;
    real         r32;
    longint      x;
    int          m;
    logic [31:0] f32;
    logic [63:0] b64;
    is_flt = 1'b0;
    nan = 1'b0;
    x = 0;
    m = 8;
    fd = 0.0;
    if (sil) return 64'd0;
    case (ifmt)
      psfc_pkg::IN_U8: begin
        x = longint'(raw[7:0]) - 128;
        m = 8;
      end
      psfc_pkg::IN_I16: begin
        x = {{48{raw[15]}}, raw[15:0]};
        m = 16;
      end
      psfc_pkg::IN_I24: begin
        x = {{40{raw[23]}}, raw[23:0]};
        m = 24;
      end
      psfc_pkg::IN_I32: begin
        x = {{32{raw[31]}}, raw[31:0]};
        m = 32;
      end
      psfc_pkg::IN_F32: begin
        f32 = raw[31:0];
        b64 = widen_f32(f32);
        nan = (f32[30:23] == 8'hff) && (f32[22:0] != 0);
        if (!nan) fd = $bitstoreal(b64);
        is_flt = 1'b1;
      end
      psfc_pkg::IN_F64: begin
        b64 = raw;
        nan = (raw[62:52] == 11'h7ff) && (raw[51:0] != 0);
        if (!nan) fd = $bitstoreal(raw);
        f32 = narrow_f64(raw);
        is_flt = 1'b1;
      end
      default: return 64'd0;
    endcase
    if (!is_flt) begin
      fd = real'(x) / real'(longint'(1) << (m - 1));
      b64 = $realtobits(fd);
      f32 = narrow_f64(b64);
    end
    case (ofmt)
      psfc_pkg::OUT_I16:     return to_pcm_int(is_flt, nan, fd, x, m, 16, 16);
      psfc_pkg::OUT_I24:     return to_pcm_int(is_flt, nan, fd, x, m, 24, 24);
      psfc_pkg::OUT_I32:     return to_pcm_int(is_flt, nan, fd, x, m, 32, 32);
      psfc_pkg::OUT_I16IN32: return to_pcm_int(is_flt, nan, fd, x, m, 16, 32);
      psfc_pkg::OUT_I24IN32: return to_pcm_int(is_flt, nan, fd, x, m, 24, 32);
      psfc_pkg::OUT_F32: begin
        if (f32[30:23] == 8'hff && f32[22:0] != 0) return {32'd0, psfc_pkg::CANON_F32};
        r32 = $bitstoreal(widen_f32(f32));
        if (r32 > 1.0) return {32'd0, psfc_pkg::ONE_F32};
        if (r32 < -1.0) return {32'd0, 1'b1, psfc_pkg::ONE_F32[30:0]};
        return {32'd0, f32};
      end
      psfc_pkg::OUT_F64: begin
        if (nan) return psfc_pkg::CANON_F64;
        if (fd > 1.0) return psfc_pkg::ONE_F64;
        if (fd < -1.0) return {1'b1, psfc_pkg::ONE_F64[62:0]};
        return b64;
      end
      default: return 64'd0;
    endcase
  endfunction

  // Pick a sample that leans on the edges of the current input format
  function automatic logic [63:0] pick_sample(logic [2:0] ifmt);
    logic [63:0] s;
    int          r;
    s = {$urandom, $urandom};
    r = $urandom_range(9);
    case (ifmt)
      psfc_pkg::IN_U8: if (r < 3) s[7:0] = (r == 0) ? 8'hff : (r == 1) ? 8'h00 : 8'h80;
      psfc_pkg::IN_I16:
        if (r < 3) s[15:0] = (r == 0) ? 16'h7fff : (r == 1) ? 16'h8000 : 16'h0000;
      psfc_pkg::IN_I24:
        if (r < 3) s[23:0] = (r == 0) ? 24'h7fffff : (r == 1) ? 24'h800000 : 24'h0;
      psfc_pkg::IN_I32:
        if (r < 3) s[31:0] = (r == 0) ? 32'h7fffffff : (r == 1) ? 32'h80000000 : 32'h0;
      psfc_pkg::IN_F32: case (r)
        0: s[30:0] = {8'hff, 23'd0};
        1: s[30:23] = 8'hff;
        2: s[30:0] = 31'd0;
        3: s[30:0] = psfc_pkg::ONE_F32[30:0];
        4: s[30:23] = 8'h00;
        5: s[30:23] = 8'($urandom_range(128, 254));
        6, 7: s[30:23] = 8'($urandom_range(100, 127));
        default: ;
      endcase
      psfc_pkg::IN_F64: case (r)
        0: s[62:0] = {11'h7ff, 52'd0};
        1: s[62:52] = 11'h7ff;
        2: s[62:0] = 63'd0;
        3: s[62:0] = psfc_pkg::ONE_F64[62:0];
        4: s[62:52] = 11'($urandom_range(0, 900));
        5: s[62:52] = 11'($urandom_range(1024, 2046));
        6, 7: s[62:52] = 11'($urandom_range(990, 1023));
        default: ;
      endcase
      default: ;
    endcase
    if (s[1] && r == 9 && ifmt == psfc_pkg::IN_F32) s[22:0] = 23'd0;
    return s;
  endfunction

  // Sample the block's outputs away from the driving edge
  always @(negedge clk_i) begin
    busy_seen = busy_o;
    if (rst_ni && done_o) sb.check(out_channel_o, out_sample_o);
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Drive one sample beat, idling now and then, and hold until accepted
  task automatic send_sample(logic [4:0] ch, logic sil, logic [63:0] smp);
    int gap;
    if ((item_cnt < 500 || item_cnt > 850) && $urandom_range(99) < 7) begin
      gap = $urandom_range(1, 4);
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i     <= 1'b1;
    channel_i   <= ch;
    silence_i   <= sil;
    in_sample_i <= smp;
    @(posedge clk_i);
    while (busy_seen) @(posedge clk_i);
    sb.note(ch, convert_sample(cur_in_fmt, cur_out_fmt, sil, smp));
    item_cnt++;
  endtask

  // Wait for every pending beat plus the pipeline depth
  task automatic drain;
    start_i <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  // Write one register, then deassert the write enable before returning
  task automatic write_reg(logic idx, logic [2:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == psfc_pkg::CFG_IN_FORMAT) cur_in_fmt = val;
    else cur_out_fmt = val;
    @(posedge clk_i);
  endtask

  initial begin
    sb = new();
    cycle_cnt   = 0;
    item_cnt    = 0;
    busy_seen   = 1'b0;
    cur_in_fmt  = psfc_pkg::IN_I16;
    cur_out_fmt = psfc_pkg::OUT_I16;
    rst_ni      = 1'b0;
    start_i     = 1'b0;
    channel_i   = '0;
    silence_i   = 1'b0;
    in_sample_i = '0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = 1'b0;
    cfg_data_i  = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed beats at the reset formats
    send_sample(5'd0, 1'b0, 64'h0000_0000_0000_7fff);
    send_sample(5'd31, 1'b0, 64'hffff_ffff_ffff_8000);
    send_sample(5'd1, 1'b0, 64'h0);
    send_sample(5'd2, 1'b0, 64'hffff_ffff_ffff_ffff);
    send_sample(5'd3, 1'b0, 64'h1234_5678_9abc_0001);
    send_sample(5'd31, 1'b1, 64'hffff_ffff_ffff_7fff);
    send_sample(5'd0, 1'b1, 64'h0);
    for (int i = 0; i < 8; i++)
      send_sample(5'($urandom), 1'b0, pick_sample(cur_in_fmt));

    // Sweep every format pair, unused codes included
    for (int fi = 0; fi < 8; fi++) begin
      for (int fo = 0; fo < 8; fo++) begin
        drain();
        write_reg(psfc_pkg::CFG_IN_FORMAT, 3'(fi));
        write_reg(psfc_pkg::CFG_OUT_FORMAT, 3'(fo));
        for (int k = 0; k < 22; k++)
          send_sample(5'($urandom), ($urandom_range(99) < 5), pick_sample(cur_in_fmt));
      end
    end

    drain();
    repeat (4) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
